// ===== rtl/core/flow_packet_rate_table_defines.svh =====
// Assertion macros for the flow packet rate table.
// Included by the modules that carry assertions; no other dependency.
`ifndef FLOW_PACKET_RATE_TABLE_DEFINES_SVH
`define FLOW_PACKET_RATE_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FPRT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPRT_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPRT_ASSERT(label, clk, rst_n, prop, msg)
`define FPRT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/fprt_pkg.sv =====
// Shared types and constants for the flow packet rate table.
// No dependencies.
`timescale 1ns / 1ps
package fprt_pkg;
    localparam int ENTRIES    = 64;
    localparam int COUNT_BITS = 32;
    localparam int IDX_BITS   = $clog2(ENTRIES);

    localparam logic [1:0] FUNC_PACKET = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;
    localparam logic [1:0] FUNC_DELETE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_EXISTS   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] remote_addr;
        logic [15:0] peer_port;
        logic [15:0] host_port;
        logic [31:0] now_ticks;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        window_rolled;
        logic [31:0] packet_count;
    } rsp_t;

    // Token passed down the cell chain: request, plus match/free results so far.
    typedef struct packed {
        logic                active;
        req_t                req;
        logic                hit;
        logic                free_found;
        logic [IDX_BITS-1:0] free_idx;
        logic [1:0]          status;
        logic                rolled;
        logic [31:0]         count;
    } tok_t;
endpackage

// ===== rtl/core/fprt_cell.sv =====
// One table entry of the flow packet rate table, a stage of the cell chain.
// Depends on fprt_pkg.
`timescale 1ns / 1ps
module fprt_cell
    import fprt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_BITS-1:0] idx,
    input  logic [30:0]         window_ticks,
    input  tok_t                tok_in,
    input  logic                commit,
    input  logic [IDX_BITS-1:0] commit_idx,
    input  tok_t                commit_tok,
    output tok_t                tok_out
);
    logic                  valid_reg;
    logic [31:0]           addr_reg;
    logic [15:0]           rport_reg;
    logic [15:0]           lport_reg;
    logic [COUNT_BITS-1:0] wcnt_reg;
    logic [31:0]           wstart_reg;
    logic [COUNT_BITS-1:0] pcnt_reg;
    logic [31:0]           pstart_reg;
    logic                  match;
    logic [31:0]           el_w;
    logic [31:0]           el_p;
    logic                  expired;
    logic                  fresh;
    tok_t                  tok_next;

    assign match = valid_reg && addr_reg == tok_in.req.remote_addr
        && rport_reg == tok_in.req.peer_port && lport_reg == tok_in.req.host_port;
    assign el_w    = tok_in.req.now_ticks - wstart_reg;
    assign el_p    = tok_in.req.now_ticks - pstart_reg;
    assign expired = el_w > {1'b0, window_ticks};
    assign fresh   = el_p <= {window_ticks, 1'b0};

    // Fold this entry into the passing token.
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && match)
        begin
            tok_next.hit = 1'b1;
            case (tok_in.req.func)
                FUNC_PACKET: tok_next.rolled = expired;
                FUNC_ADD:    tok_next.status = ST_EXISTS;
                FUNC_QUERY:
                    if (fresh)
                        tok_next.count = (COUNT_BITS > 32 && (pcnt_reg >> 32) != 0)
                            ? 32'hFFFF_FFFF : 32'(pcnt_reg);
                default: ;
            endcase
        end
        if (tok_in.active && !valid_reg && !tok_in.free_found)
        begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = idx;
        end
    end

    // Advance the token one cell per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_out <= '0;
        else
            tok_out <= tok_next;
    end

    // Update entry: packet/delete act on the match in passing, add commits at chain end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (commit && commit_idx == idx)
            valid_reg <= 1'b1;
        else if (tok_in.active && match && tok_in.req.func == FUNC_DELETE)
            valid_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (commit && commit_idx == idx)
        begin
            addr_reg   <= commit_tok.req.remote_addr;
            rport_reg  <= commit_tok.req.peer_port;
            lport_reg  <= commit_tok.req.host_port;
            wcnt_reg   <= '0;
            wstart_reg <= commit_tok.req.now_ticks;
            pcnt_reg   <= '0;
            pstart_reg <= commit_tok.req.now_ticks - {1'b0, window_ticks};
        end
        else if (tok_in.active && match && tok_in.req.func == FUNC_PACKET)
        begin
            if (expired)
            begin
                pcnt_reg   <= wcnt_reg;
                pstart_reg <= wstart_reg;
                wcnt_reg   <= '0;
                wstart_reg <= tok_in.req.now_ticks;
            end
            else if (wcnt_reg != {COUNT_BITS{1'b1}})
                wcnt_reg <= wcnt_reg + 1'b1;
        end
    end
endmodule

// ===== rtl/core/flow_packet_rate_table.sv =====
// Top level of the flow packet rate table: handshake, cell chain, result register.
// Depends on fprt_pkg, fprt_cell and flow_packet_rate_table_defines.svh.
`timescale 1ns / 1ps
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | req_t
//  rsp     | out       | rsp_valid/stall  | rsp_t
//  cfg     | in        | cfg_we           | cfg_data (window_ticks)
// A request walks the chain of ENTRIES cells, one cell a cycle; its result
// leaves the last cell and is registered in the output register. One request
// is in flight at a time, so a new request is taken only after the result
// has transferred, and later still while rsp stalls.
// Reset clears all entries at once; window_ticks resets to 1000.
// The result waits in an output register; a stall on rsp holds it there.
`include "flow_packet_rate_table_defines.svh"
module flow_packet_rate_table
    import fprt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [30:0] cfg_data
);
    logic [30:0] wticks_reg;
    logic        busy_reg;
    tok_t        chain [ENTRIES+1];
    tok_t        last;
    logic        commit;
    logic        last_rolled;

    // Hold configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wticks_reg <= 31'd1000;
        else if (cfg_we)
            wticks_reg <= cfg_data;
    end

    assign req_stall = busy_reg;

    // Inject a fresh token on transfer.
    always_comb
    begin
        chain[0]             = '0;
        chain[0].active      = req_valid && !busy_reg;
        chain[0].req         = req;
    end

    assign last   = chain[ENTRIES];
    assign commit = last.active && last.req.func == FUNC_ADD && !last.hit
        && last.free_found;
    assign last_rolled = last.active && last.rolled;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        fprt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .idx         (IDX_BITS'(g)),
            .window_ticks(wticks_reg),
            .tok_in      (chain[g]),
            .commit      (commit),
            .commit_idx  (last.free_idx),
            .commit_tok  (last),
            .tok_out     (chain[g+1])
        );
    end

    // Track the request in flight and present its result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            rsp_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !busy_reg)
                busy_reg <= 1'b1;
            else if (rsp_valid && !rsp_stall)
                busy_reg <= 1'b0;
            if (last.active)
                rsp_valid <= 1'b1;
            else if (!rsp_stall)
                rsp_valid <= 1'b0;
        end
    end
    always_ff @(posedge clk)
    begin
        if (last.active)
        begin
            rsp.window_rolled <= last.rolled;
            rsp.packet_count  <= last.count;
            if (last.req.func == FUNC_ADD)
                rsp.status <= last.hit ? ST_EXISTS
                    : (last.free_found ? ST_OK : ST_FULL);
            else
                rsp.status <= last.hit ? ST_OK : ST_NOTFOUND;
        end
    end

    `FPRT_ASSERT(a_no_rsp_idle, clk, rst_n, rsp_valid |-> busy_reg, "result without request")
    `FPRT_ASSERT(a_done_busy, clk, rst_n, last.active |-> busy_reg, "token while idle")
    `FPRT_ASSERT(a_roll_pkt, clk, rst_n, last_rolled |-> last.req.func == FUNC_PACKET, "bad roll")
endmodule

// ===== tb/sv/fprt_checker.sv =====
// Scoreboard for the flow packet rate table: watches the request, response and
// register ports, predicts every response and compares it. Depends on fprt_pkg.
`timescale 1ns / 1ps
module fprt_checker
    import fprt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_t        req,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [30:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          checked,
    output int          rolled_seen,
    output int          full_seen
);
    // Shadow copy of the flow table and the window length
    logic [30:0]           win_len;
    logic                  flow_used  [ENTRIES];
    logic [31:0]           flow_addr  [ENTRIES];
    logic [15:0]           flow_rport [ENTRIES];
    logic [15:0]           flow_lport [ENTRIES];
    logic [COUNT_BITS-1:0] cur_count  [ENTRIES];
    logic [31:0]           cur_start  [ENTRIES];
    logic [COUNT_BITS-1:0] last_count [ENTRIES];
    logic [31:0]           last_start [ENTRIES];
    rsp_t                  rate_answers [$];

    // Apply one request to the shadow table and return the response it must give
    function automatic rsp_t apply_request(req_t r);
        rsp_t        a;
        int          hit;
        int          slot;
        logic [31:0] el;
        a = '0;
        a.status = ST_OK;
        hit = -1;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && flow_used[i] && flow_addr[i] == r.remote_addr &&
                flow_rport[i] == r.peer_port && flow_lport[i] == r.host_port)
                hit = i;
            if (slot < 0 && !flow_used[i])
                slot = i;
        end
        case (r.func)
            FUNC_PACKET:
            begin
                if (hit < 0)
                    a.status = ST_NOTFOUND;
                else
                begin
                    el = r.now_ticks - cur_start[hit];
                    if (el > {1'b0, win_len})
                    begin
                        last_count[hit] = cur_count[hit];
                        last_start[hit] = cur_start[hit];
                        cur_count[hit]  = '0;
                        cur_start[hit]  = r.now_ticks;
                        a.window_rolled = 1'b1;
                    end
                    else if (cur_count[hit] != '1)
                        cur_count[hit] = cur_count[hit] + 1'b1;
                end
            end
            FUNC_ADD:
            begin
                if (hit >= 0)
                    a.status = ST_EXISTS;
                else if (slot < 0)
                    a.status = ST_FULL;
                else
                begin
                    flow_used[slot]  = 1'b1;
                    flow_addr[slot]  = r.remote_addr;
                    flow_rport[slot] = r.peer_port;
                    flow_lport[slot] = r.host_port;
                    cur_count[slot]  = '0;
                    cur_start[slot]  = r.now_ticks;
                    last_count[slot] = '0;
                    last_start[slot] = r.now_ticks - {1'b0, win_len};
                end
            end
            FUNC_QUERY:
            begin
                if (hit < 0)
                    a.status = ST_NOTFOUND;
                else
                begin
                    el = r.now_ticks - last_start[hit];
                    if (el <= {win_len, 1'b0})
                        a.packet_count = last_count[hit];
                end
            end
            default:
            begin
                if (hit < 0)
                    a.status = ST_NOTFOUND;
                else
                    flow_used[hit] = 1'b0;
            end
        endcase
        return a;
    endfunction

    // Track transfers on all ports and compare responses in order
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            win_len = 31'd1000;
            for (int i = 0; i < ENTRIES; i++)
                flow_used[i] = 1'b0;
            rate_answers.delete();
            errors      <= 0;
            pending     <= 0;
            checked     <= 0;
            rolled_seen <= 0;
            full_seen   <= 0;
        end
        else
        begin
            if (cfg_we)
                win_len = cfg_data;
            if (rsp_valid && !rsp_stall)
            begin
                if (rate_answers.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("%0t: unexpected response %p", $realtime, rsp);
                end
                else
                begin
                    want = rate_answers.pop_front();
                    checked <= checked + 1;
                    if (rsp.window_rolled)
                        rolled_seen <= rolled_seen + 1;
                    if (rsp.status == ST_FULL)
                        full_seen <= full_seen + 1;
                    if (rsp.status !== want.status || rsp.window_rolled !== want.window_rolled ||
                        rsp.packet_count !== want.packet_count)
                    begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display("%0t: mismatch status %0d/%0d rolled %0d/%0d count %0d/%0d",
                                     $realtime, want.status, rsp.status, want.window_rolled,
                                     rsp.window_rolled, want.packet_count, rsp.packet_count);
                    end
                end
            end
            if (req_valid && !req_stall)
                rate_answers.push_back(apply_request(req));
            pending <= rate_answers.size();
        end
    end
endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the flow packet rate table testbench: clock, reset, request and
// register stimulus, response back-pressure, verdict. Depends on fprt_pkg, fprt_checker.
`timescale 1ns / 1ps
module tb_top;
    import fprt_pkg::*;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] rport;
        logic [15:0] lport;
    } flow_key_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        cfg_we;
    logic [30:0] cfg_data;
    int          errors;
    int          pending;
    int          checked;
    int          rolled_seen;
    int          full_seen;

    flow_key_t   key_pool [16];
    logic [31:0] clock_now;
    logic [30:0] cur_win;
    int          sent;

    flow_packet_rate_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    fprt_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked),
        .rolled_seen (rolled_seen),
        .full_seen   (full_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    // Random back-pressure on responses, with one long hold that blocks new requests
    initial
    begin
        int cyc;
        bit held;
        cyc = 0;
        held = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!held && cyc > 4000)
            begin
                held = 1;
                rsp_stall <= 1'b1;
                repeat (500) @(posedge clk);
            end
            else if ($urandom_range(0, 99) < 3)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(10, 60)) @(posedge clk);
            end
            else if ($urandom_range(0, 99) < 5)
            begin
                rsp_stall <= 1'b0;
                repeat ($urandom_range(20, 100)) @(posedge clk);
            end
            else
                rsp_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    function automatic req_t make_req(logic [1:0] f, flow_key_t k, logic [31:0] t);
        req_t r;
        r.func        = f;
        r.remote_addr = k.addr;
        r.peer_port   = k.rport;
        r.host_port   = k.lport;
        r.now_ticks   = t;
        return r;
    endfunction

    // Offer one request, hold it until transfer, then idle for a random gap, sometimes none
    task automatic send(req_t r);
        int gap;
        int pick;
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        sent++;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            gap = 0;
        else if (pick < 95)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(20, 120);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain all responses, then let the block settle
    task automatic wait_idle();
        int guard;
        req_valid <= 1'b0;
        repeat (2) @(posedge clk);
        guard = 0;
        while (pending != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (ENTRIES + 10) @(posedge clk);
    endtask

    task automatic set_window(logic [30:0] v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        cur_win = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Step time forward mostly within a window, sometimes past it or anywhere
    function automatic logic [31:0] next_now();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return clock_now + $urandom_range(0, cur_win / 2 + 1);
        else if (pick < 95)
            return clock_now + cur_win + $urandom_range(1, 3);
        else
            return $urandom;
    endfunction

    task automatic random_items(int n);
        flow_key_t k;
        int        pick;
        logic [1:0] f;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                f = FUNC_PACKET;
            else if (pick < 65)
                f = FUNC_ADD;
            else if (pick < 90)
                f = FUNC_QUERY;
            else
                f = FUNC_DELETE;
            if ($urandom_range(0, 99) < 5)
                k = {$urandom, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
            else
                k = key_pool[$urandom_range(0, 15)];
            clock_now = next_now();
            send(make_req(f, k, clock_now));
        end
    endtask

    // Add distinct flows past the table size, then remove them all
    task automatic fill_table();
        flow_key_t fk [ENTRIES + 2];
        for (int i = 0; i < ENTRIES + 2; i++)
        begin
            fk[i] = {32'hA000_0000 + i, 16'h5555, 16'hAAAA};
            send(make_req(FUNC_ADD, fk[i], clock_now));
        end
        for (int i = 0; i < ENTRIES + 2; i++)
            send(make_req(FUNC_DELETE, fk[i], clock_now));
    endtask

    initial
    begin
        flow_key_t kmax;
        flow_key_t kmin;
        logic [30:0] windows [4];
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        sent      = 0;
        cur_win   = 31'd1000;
        kmax = '1;
        kmin = '0;
        key_pool[0] = kmax;
        key_pool[1] = kmin;
        for (int i = 2; i < 16; i++)
            key_pool[i] = {$urandom, 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535))};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: missing key, add and duplicate, counting, roll, stale query, delete
        clock_now = 32'hFFFF_FF00;
        send(make_req(FUNC_PACKET, kmax, clock_now));
        send(make_req(FUNC_QUERY,  kmax, clock_now));
        send(make_req(FUNC_DELETE, kmax, clock_now));
        send(make_req(FUNC_ADD,    kmax, clock_now));
        send(make_req(FUNC_ADD,    kmax, clock_now));
        send(make_req(FUNC_QUERY,  kmax, clock_now + 10));
        send(make_req(FUNC_PACKET, kmax, clock_now + 10));
        send(make_req(FUNC_PACKET, kmax, clock_now + 1000));
        send(make_req(FUNC_PACKET, kmax, clock_now + 1001));
        send(make_req(FUNC_QUERY,  kmax, clock_now + 1500));
        send(make_req(FUNC_QUERY,  kmax, clock_now + 3001));
        send(make_req(FUNC_QUERY,  kmax, clock_now + 3002));
        send(make_req(FUNC_ADD,    kmin, 32'h0));
        send(make_req(FUNC_PACKET, kmin, 32'h7FFF_FFFF));
        send(make_req(FUNC_DELETE, kmax, clock_now));
        send(make_req(FUNC_QUERY,  kmax, clock_now));
        send(make_req(FUNC_DELETE, kmin, clock_now));
        clock_now = clock_now + 4000;

        // Random phases across window lengths, extremes included
        windows[0] = 31'd0;
        windows[1] = 31'h7FFF_FFFF;
        windows[2] = 31'd1;
        windows[3] = $urandom_range(20, 5000);
        random_items(130);
        fill_table();
        for (int p = 0; p < 4; p++)
        begin
            set_window(windows[p]);
            random_items(130);
        end

        wait_idle();
        $display("Sent %0d requests over five window lengths; checked %0d responses",
                 sent, checked);
        $display("Saw %0d window rolls and %0d table-full rejections", rolled_seen, full_seen);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/fprt_pkg.sv
rtl/core/fprt_cell.sv
rtl/core/flow_packet_rate_table.sv
tb/sv/fprt_checker.sv
tb/sv/tb_top.sv
